// ===== rtl/rule_based_text_tokenizer_defines.svh =====
// assertion macros for the text tokenizer
// depends on clk and rst being visible where the macros are used
`ifndef RULE_BASED_TEXT_TOKENIZER_DEFINES_SVH
`define RULE_BASED_TEXT_TOKENIZER_DEFINES_SVH

// property checked on every clock edge outside reset
`define RBTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define RBTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rbtt_pkg.sv =====
// types and constants for the text tokenizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rbtt_pkg;

  localparam int POS_BITS   = 16;
  localparam int LEN_BITS   = 16;
  localparam int KIND_BITS  = 3;
  localparam int ABBR_BITS  = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_BITS-1:0]  LEN_MAX       = '1;
  localparam logic [ABBR_BITS-1:0] ABBR_RST      = ABBR_BITS'(4);

  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [LEN_BITS-1:0]  len_t;
  typedef logic [ABBR_BITS-1:0] abbr_t;

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_WORD   = 3'd1,
    ST_NUMBER = 3'd2,
    ST_PUNCT  = 3'd3,
    ST_CONTR  = 3'd4,
    ST_ABBREV = 3'd5,
    ST_HYPHEN = 3'd6
  } scan_state_t;

  typedef enum logic [2:0] {
    CL_LETTER = 3'd0,
    CL_DIGIT  = 3'd1,
    CL_PERIOD = 3'd2,
    CL_APOS   = 3'd3,
    CL_HYPHEN = 3'd4,
    CL_PUNCT  = 3'd5,
    CL_SPACE  = 3'd6
  } char_class_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_WORD   = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_PUNCT  = 3'd2,
    KIND_CONTR  = 3'd3,
    KIND_ABBREV = 3'd4,
    KIND_HYPHEN = 3'd5
  } token_kind_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    pos_t                 start_pos;
    pos_t                 end_pos;
    len_t                 len;
    logic                 last;
  } result_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cls;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      cls = CL_LETTER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = CL_DIGIT;
    end else if (c == 8'h2E) begin
      cls = CL_PERIOD;
    end else if (c == 8'h27) begin
      cls = CL_APOS;
    end else if (c == 8'h2D) begin
      cls = CL_HYPHEN;
    end else if (c >= 8'h21 && c <= 8'h7E) begin
      cls = CL_PUNCT;
    end else begin
      cls = CL_SPACE;
    end
    return cls;
  endfunction

  function automatic logic [KIND_BITS-1:0] kind_of(input scan_state_t st);
    logic [KIND_BITS-1:0] k;
    unique case (st)
      ST_WORD:   k = KIND_WORD;
      ST_NUMBER: k = KIND_NUMBER;
      ST_PUNCT:  k = KIND_PUNCT;
      ST_CONTR:  k = KIND_CONTR;
      ST_ABBREV: k = KIND_ABBREV;
      ST_HYPHEN: k = KIND_HYPHEN;
      default:   k = '1;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rule_based_text_tokenizer.sv =====
// A token is written into the result queue when the byte that ends it is transferred.
// Throughput: one byte per cycle while in_stall is low; the byte classifier and one scan state
// transition sit between the state registers and a four-entry result queue.
// The input stalls while fewer than two queue entries are free.
// Reset: synchronous; scan state start, positions and length zero,
// abbrev_max_len 4, result queue empty.
// depends on rbtt_pkg and rule_based_text_tokenizer_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "rule_based_text_tokenizer_defines.svh"

module rule_based_text_tokenizer
  import rbtt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 abbrev_max_len_we,
  input  wire logic [ABBR_BITS-1:0] abbrev_max_len_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           ch,
  input  wire logic                 end_of_text,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [KIND_BITS-1:0]      token_kind,
  output pos_t                      start_pos,
  output pos_t                      end_pos,
  output len_t                      token_len,
  output logic                      run_last
);

  scan_state_t scan_state, scan_state_next;
  pos_t        token_begin, token_begin_next;
  pos_t        position, position_next;
  len_t        pending_len, pending_len_next;
  abbr_t       abbrev_max_len;

  result_t               queue [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]   count, count_next;

  logic        in_xfer, out_xfer;
  char_class_t cls;
  pos_t        prev_pos;
  result_t     res0, res1;
  logic        res0_en, res1_en;
  logic [1:0]  nwr;

  assign in_stall  = count > CNT_BITS'(FIFO_DEPTH - 2);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = count != '0;
  assign out_xfer  = out_valid && !out_stall;

  assign cls      = classify(ch);
  assign prev_pos = position - pos_t'(1);

  always_comb begin
    logic        boundary;
    logic        start_tok;
    scan_state_t st;
    len_t        len;
    pos_t        tb;
    st       = scan_state;
    len      = pending_len;
    tb       = token_begin;
    boundary = 1'b0;
    res0     = '0;
    res1     = '0;
    res0_en  = 1'b0;
    res1_en  = 1'b0;

    unique case (scan_state)
      ST_START: begin
      end
      ST_WORD: begin
        if (cls == CL_LETTER) begin
          if (len != LEN_MAX) len = len + len_t'(1);
        end else if (cls == CL_PERIOD) begin
          if (({1'b0, len} + 17'd1) <= {{(LEN_BITS + 1 - ABBR_BITS){1'b0}}, abbrev_max_len})
          begin
            if (len != LEN_MAX) len = len + len_t'(1);
            st = ST_ABBREV;
          end else begin
            boundary = 1'b1;
          end
        end else if (cls == CL_APOS) begin
          if (len != LEN_MAX) len = len + len_t'(1);
          st = ST_CONTR;
        end else if (cls == CL_HYPHEN) begin
          if (len != LEN_MAX) len = len + len_t'(1);
          st = ST_HYPHEN;
        end else begin
          boundary = 1'b1;
        end
      end
      ST_NUMBER: begin
        if (cls == CL_DIGIT) begin
          if (len != LEN_MAX) len = len + len_t'(1);
        end else begin
          boundary = 1'b1;
        end
      end
      ST_PUNCT: begin
        if (cls == CL_PUNCT || cls == CL_PERIOD) begin
          if (len != LEN_MAX) len = len + len_t'(1);
        end else begin
          boundary = 1'b1;
        end
      end
      ST_ABBREV: begin
        if (cls == CL_LETTER) begin
          if (len != LEN_MAX) len = len + len_t'(1);
          st = ST_WORD;
        end else if (cls == CL_PERIOD) begin
          if (len != LEN_MAX) len = len + len_t'(1);
        end else begin
          boundary = 1'b1;
        end
      end
      ST_CONTR, ST_HYPHEN: begin
        if (cls == CL_LETTER) begin
          if (len != LEN_MAX) len = len + len_t'(1);
          st = ST_WORD;
        end else begin
          boundary = 1'b1;
        end
      end
      default: begin
        st  = ST_START;
        len = '0;
      end
    endcase

    // token that the current byte closes
    if (boundary) begin
      res0_en        = 1'b1;
      res0.kind      = kind_of(st);
      res0.start_pos = tb;
      res0.end_pos   = prev_pos;
      res0.len       = len;
      st             = ST_START;
      len            = '0;
    end

    // restart from the start state
    start_tok = (st == ST_START);
    if (start_tok) begin
      if (cls == CL_LETTER) begin
        st = ST_WORD;
      end else if (cls == CL_DIGIT) begin
        st = ST_NUMBER;
      end else if (cls == CL_PUNCT || cls == CL_PERIOD) begin
        st = ST_PUNCT;
      end
      if (st != ST_START) begin
        tb  = position;
        len = len_t'(1);
      end
    end

    // flush at end of string
    if (end_of_text) begin
      if (st != ST_START) begin
        res1_en        = 1'b1;
        res1.kind      = kind_of(st);
        res1.start_pos = tb;
        res1.end_pos   = position;
        res1.len       = len;
        res1.last      = 1'b1;
      end
      st            = ST_START;
      len           = '0;
      position_next = '0;
    end else begin
      position_next = position + pos_t'(1);
    end
    res0.last = !res1_en;

    scan_state_next  = st;
    token_begin_next = tb;
    pending_len_next = len;
  end

  always_comb begin
    nwr = 2'd0;
    if (in_xfer) begin
      nwr = {1'b0, res0_en} + {1'b0, res1_en};
    end
    count_next = count + CNT_BITS'(nwr) - CNT_BITS'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= ST_START;
      token_begin    <= '0;
      position       <= '0;
      pending_len    <= '0;
      abbrev_max_len <= ABBR_RST;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (abbrev_max_len_we) begin
        abbrev_max_len <= abbrev_max_len_wdata;
      end
      if (in_xfer) begin
        scan_state  <= scan_state_next;
        token_begin <= token_begin_next;
        position    <= position_next;
        pending_len <= pending_len_next;
        wr_ptr      <= wr_ptr + PTR_BITS'(nwr);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count_next;
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (res0_en) begin
        queue[wr_ptr] <= res0;
        if (res1_en) begin
          queue[wr_ptr + PTR_BITS'(1)] <= res1;
        end
      end else if (res1_en) begin
        queue[wr_ptr] <= res1;
      end
    end
  end

  assign token_kind = queue[rd_ptr].kind;
  assign start_pos  = queue[rd_ptr].start_pos;
  assign end_pos    = queue[rd_ptr].end_pos;
  assign token_len  = queue[rd_ptr].len;
  assign run_last   = queue[rd_ptr].last;

  `RBTT_ASSERT(a_count_bound, count <= CNT_BITS'(FIFO_DEPTH), "result queue overflow")
  `RBTT_ASSERT(a_eot_pos, in_xfer && end_of_text |=> position == '0, "position not cleared")
  `RBTT_ASSERT(a_not_last_pair, out_valid && !run_last |-> count >= CNT_BITS'(2), "pair split")
  `RBTT_ASSERT(a_start_len, scan_state == ST_START |-> pending_len == '0, "length left in start")

endmodule

`default_nettype wire

// ===== tb/rbtt_token_checker.sv =====
// token checker for the rule based text tokenizer: follows every byte transfer,
// predicts the tokens each byte closes and compares every result transfer in order
// depends on rbtt_pkg
`timescale 1ns / 1ps

module rbtt_token_checker
  import rbtt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 abbrev_max_len_we,
  input  abbr_t                abbrev_max_len_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           ch,
  input  logic                 end_of_text,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [KIND_BITS-1:0] token_kind,
  input  pos_t                 start_pos,
  input  pos_t                 end_pos,
  input  len_t                 token_len,
  input  logic                 run_last,
  output int                   bad_tokens,
  output int                   tokens_waiting
);

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    pos_t                 first_at;
    pos_t                 last_at;
    len_t                 len;
    logic                 closes_byte;
  } token_t;

  token_t      tokens_due[$];
  scan_state_t scan;
  pos_t        tok_first;
  pos_t        cur_pos;
  len_t        tok_len;
  abbr_t       abbr_limit;
  int          shown = 0;

  function automatic char_class_t byte_class(input logic [7:0] c);
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CL_LETTER;
    if (c >= "0" && c <= "9") return CL_DIGIT;
    case (c)
      ".":     return CL_PERIOD;
      "'":     return CL_APOS;
      "-":     return CL_HYPHEN;
      default: return (c > 8'h20 && c < 8'h7F) ? CL_PUNCT : CL_SPACE;
    endcase
  endfunction

  function automatic logic [KIND_BITS-1:0] kind_for(input scan_state_t s);
    case (s)
      ST_NUMBER: return KIND_NUMBER;
      ST_PUNCT:  return KIND_PUNCT;
      ST_CONTR:  return KIND_CONTR;
      ST_ABBREV: return KIND_ABBREV;
      ST_HYPHEN: return KIND_HYPHEN;
      default:   return KIND_WORD;
    endcase
  endfunction

  task automatic lengthen();
    if (tok_len != '1) tok_len = tok_len + 1'b1;
  endtask

  task automatic close_token(input pos_t last_at);
    token_t t;
    t.kind        = kind_for(scan);
    t.first_at    = tok_first;
    t.last_at     = last_at;
    t.len         = tok_len;
    t.closes_byte = 1'b0;
    tokens_due.insert(tokens_due.size(), t);
    scan    = ST_START;
    tok_len = '0;
  endtask

  task automatic open_token(input char_class_t cls);
    case (cls)
      CL_LETTER:           scan = ST_WORD;
      CL_DIGIT:            scan = ST_NUMBER;
      CL_PERIOD, CL_PUNCT: scan = ST_PUNCT;
      default:             scan = ST_START;
    endcase
    if (scan != ST_START) begin
      tok_first = cur_pos;
      tok_len   = 16'd1;
    end
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic eot);
    char_class_t cls;
    logic        brk;
    int          due_before;
    cls        = byte_class(c);
    brk        = 1'b0;
    due_before = tokens_due.size();
    case (scan)
      ST_START: open_token(cls);
      ST_WORD: begin
        if (cls == CL_LETTER) begin
          lengthen();
        end else if (cls == CL_PERIOD && int'(tok_len) + 1 <= int'(abbr_limit)) begin
          lengthen();
          scan = ST_ABBREV;
        end else if (cls == CL_APOS) begin
          lengthen();
          scan = ST_CONTR;
        end else if (cls == CL_HYPHEN) begin
          lengthen();
          scan = ST_HYPHEN;
        end else begin
          brk = 1'b1;
        end
      end
      ST_NUMBER: begin
        if (cls == CL_DIGIT) lengthen();
        else brk = 1'b1;
      end
      ST_PUNCT: begin
        if (cls == CL_PUNCT || cls == CL_PERIOD) lengthen();
        else brk = 1'b1;
      end
      ST_ABBREV: begin
        if (cls == CL_LETTER) begin
          lengthen();
          scan = ST_WORD;
        end else if (cls == CL_PERIOD) begin
          lengthen();
        end else begin
          brk = 1'b1;
        end
      end
      ST_CONTR, ST_HYPHEN: begin
        if (cls == CL_LETTER) begin
          lengthen();
          scan = ST_WORD;
        end else begin
          brk = 1'b1;
        end
      end
      default: begin
        scan    = ST_START;
        tok_len = '0;
        open_token(cls);
      end
    endcase
    // boundary byte closes the token and is scanned again from start
    if (brk) begin
      close_token(cur_pos - 1'b1);
      open_token(cls);
    end
    if (eot) begin
      if (scan != ST_START) close_token(cur_pos);
      scan    = ST_START;
      tok_len = '0;
      cur_pos = '0;
    end else begin
      cur_pos = cur_pos + 1'b1;
    end
    if (tokens_due.size() > due_before) begin
      tokens_due[tokens_due.size() - 1].closes_byte = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    if (rst) begin
      scan       = ST_START;
      tok_first  = '0;
      cur_pos    = '0;
      tok_len    = '0;
      abbr_limit = ABBR_RST;
      bad_tokens = 0;
      tokens_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          bad_tokens++;
          if (shown < 10) begin
            $display("unexpected token: kind %0d start %0d end %0d len %0d last %0b",
                     token_kind, start_pos, end_pos, token_len, run_last);
          end
          shown++;
        end else begin
          want = tokens_due.pop_front();
          if (token_kind !== want.kind || start_pos !== want.first_at ||
              end_pos !== want.last_at || token_len !== want.len ||
              run_last !== want.closes_byte) begin
            bad_tokens++;
            if (shown < 10) begin
              $display("token mismatch: want kind %0d start %0d end %0d len %0d last %0b",
                       want.kind, want.first_at, want.last_at, want.len, want.closes_byte);
              $display("                got  kind %0d start %0d end %0d len %0d last %0b",
                       token_kind, start_pos, end_pos, token_len, run_last);
            end
            shown++;
          end
        end
      end
      if (abbrev_max_len_we) abbr_limit = abbrev_max_len_wdata;
      if (in_valid && !in_stall) scan_byte(ch, end_of_text);
    end
    tokens_waiting = tokens_due.size();
  end

endmodule

// ===== tb/rule_based_text_tokenizer_tb.sv =====
// top of the text tokenizer testbench: clock, reset, byte stimulus, limit writes
// and output stalls; verdict from the failure count of rbtt_token_checker
// depends on rbtt_pkg, rule_based_text_tokenizer and rbtt_token_checker
`timescale 1ns / 1ps

module rule_based_text_tokenizer_tb;
  import rbtt_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 abbrev_max_len_we = 1'b0;
  abbr_t                abbrev_max_len_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           ch = 8'h00;
  logic                 end_of_text = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_BITS-1:0] token_kind;
  pos_t                 start_pos;
  pos_t                 end_pos;
  len_t                 token_len;
  logic                 run_last;
  int                   bad_tokens;
  int                   tokens_waiting;
  logic                 idle_on = 1'b0;
  int                   stall_left = 0;
  int                   bytes_sent = 0;

  rule_based_text_tokenizer dut (
    .clk                  (clk),
    .rst                  (rst),
    .abbrev_max_len_we    (abbrev_max_len_we),
    .abbrev_max_len_wdata (abbrev_max_len_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .ch                   (ch),
    .end_of_text          (end_of_text),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .token_kind           (token_kind),
    .start_pos            (start_pos),
    .end_pos              (end_pos),
    .token_len            (token_len),
    .run_last             (run_last)
  );

  rbtt_token_checker tok_chk (
    .clk                  (clk),
    .rst                  (rst),
    .abbrev_max_len_we    (abbrev_max_len_we),
    .abbrev_max_len_wdata (abbrev_max_len_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .ch                   (ch),
    .end_of_text          (end_of_text),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .token_kind           (token_kind),
    .start_pos            (start_pos),
    .end_pos              (end_pos),
    .token_len            (token_len),
    .run_last             (run_last),
    .bad_tokens           (bad_tokens),
    .tokens_waiting       (tokens_waiting)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side holds stall for runs of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_mark();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(33, 126));
    end while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "." || c == "'" || c == "-");
    return c;
  endfunction

  function automatic logic [7:0] rand_gap_byte();
    case ($urandom_range(0, 5))
      0, 1:    return " ";
      2:       return 8'h09;
      3:       return 8'($urandom_range(128, 255));
      4:       return 8'h00;
      default: return 8'h7F;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    ch          <= c;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic eot_last);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], eot_last && i == s.len() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tokens_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_abbrev_limit(input abbr_t v);
    wait_idle();
    abbrev_max_len_we    <= 1'b1;
    abbrev_max_len_wdata <= v;
    @(negedge clk);
    abbrev_max_len_we    <= 1'b0;
  endtask

  // one chunk of text: a word-like token, number, marks or noise, then a separator byte, always if otherwise empty
  task automatic send_piece();
    logic [7:0] text[$];
    int         r;
    int         i;
    logic       eot;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      repeat ($urandom_range(1, 9)) text.insert(text.size(), rand_letter());
      case ($urandom_range(0, 5))
        0: begin
          text.insert(text.size(), ".");
          case ($urandom_range(0, 3))
            0: begin
              text.insert(text.size(), rand_letter());
              text.insert(text.size(), ".");
            end
            1: text.insert(text.size(), ".");
            2: repeat ($urandom_range(1, 3)) text.insert(text.size(), rand_letter());
            default: ;
          endcase
        end
        1: begin
          text.insert(text.size(), "'");
          repeat ($urandom_range(0, 2)) text.insert(text.size(), rand_letter());
        end
        2: begin
          text.insert(text.size(), "-");
          repeat ($urandom_range(0, 4)) text.insert(text.size(), rand_letter());
        end
        default: ;
      endcase
    end else if (r < 60) begin
      repeat ($urandom_range(1, 5)) text.insert(text.size(), rand_digit());
    end else if (r < 72) begin
      repeat ($urandom_range(1, 3)) begin
        text.insert(text.size(), ($urandom_range(0, 9) < 3) ? 8'h2E : rand_mark());
      end
    end else if (r < 85) begin
      repeat ($urandom_range(1, 3)) text.insert(text.size(), 8'($urandom_range(0, 255)));
    end
    if (text.size() == 0 || $urandom_range(0, 99) < 85) begin
      text.insert(text.size(), rand_gap_byte());
    end
    eot = ($urandom_range(0, 7) == 0);
    for (i = 0; i < text.size(); i++) send_byte(text[i], eot && i == text.size() - 1);
  endtask

  initial begin
    #10_000_000;
    $display("rule_based_text_tokenizer_tb: errors");
    $finish;
  end

  initial begin
    int    phase;
    abbr_t lim;
    repeat (12) @(negedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;
    @(negedge clk);

    // ignored leading marks, abbreviation, contraction, hyphen, boundaries
    send_text("'-Mr.s't-x90!.", 1'b0);
    send_byte(8'h80, 1'b0);
    // flushes by state at end of text, two tokens from one byte
    send_text("a'", 1'b1);
    send_text("7", 1'b1);
    send_text("b-", 1'b1);
    send_text("ab!", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("~", 1'b0);
    send_byte(" ", 1'b1);

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       lim = 3'd7;
        1:       lim = 3'd0;
        2:       lim = 3'd1;
        3:       lim = 3'd2;
        default: lim = abbr_t'($urandom_range(0, 7));
      endcase
      set_abbrev_limit(lim);
      idle_on    <= 1'b1;
      bytes_sent = 0;
      while (bytes_sent < 200) begin
        send_piece();
        if ($urandom_range(0, 15) == 0) idle_on <= ~idle_on;
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (bad_tokens == 0) begin
      $display("rule_based_text_tokenizer_tb: clean");
    end else begin
      $display("rule_based_text_tokenizer_tb: errors");
    end
    $finish;
  end

endmodule

// ===== rule_based_text_tokenizer.f =====
+incdir+rtl
rtl/rbtt_pkg.sv
rtl/rule_based_text_tokenizer.sv
tb/rbtt_token_checker.sv
tb/rule_based_text_tokenizer_tb.sv
